FILE: src/rlpe_pkg.sv
`default_nettype none
package rlpe_pkg;

    localparam int COUNT_WIDTH_DEF = 16;
    localparam int LEN_WIDTH = 16;
    localparam int CFG_INDEX_WIDTH = 2;
    localparam int MAX_RESULTS = 3;
    localparam int RES_IDX_WIDTH = 2;

    typedef logic [7:0] byte_t;

    localparam byte_t CH_STAR      = 8'h2A;
    localparam byte_t CH_QMARK     = 8'h3F;
    localparam byte_t CH_BAR       = 8'h7C;
    localparam byte_t CH_Q         = 8'h51;
    localparam byte_t CH_E         = 8'h45;
    localparam byte_t CH_HASH      = 8'h23;
    localparam byte_t CH_CARET     = 8'h5E;
    localparam byte_t CH_A         = 8'h41;
    localparam byte_t CH_BACKSLASH = 8'h5C;
    localparam byte_t CH_DOLLAR    = 8'h24;
    localparam byte_t CH_DOT       = 8'h2E;
    localparam byte_t CH_LBRACKET  = 8'h5B;
    localparam byte_t CH_LPAREN    = 8'h28;
    localparam byte_t CH_RPAREN    = 8'h29;
    localparam byte_t CH_PLUS      = 8'h2B;
    localparam byte_t CH_LBRACE    = 8'h7B;
    localparam byte_t CH_SPACE     = 8'h20;

    typedef enum logic [CFG_INDEX_WIDTH-1:0] {
        REG_FLAG_MULTILINE   = 2'd0,
        REG_FLAG_EXTENDED    = 2'd1,
        REG_FLAG_UNSUPPORTED = 2'd2
    } reg_index_t;

    typedef enum logic [2:0] {
        M_START    = 3'd0,
        M_START_BS = 3'd1,
        M_SCAN     = 3'd2,
        M_SCAN_BS  = 3'd3,
        M_QUOTE    = 3'd4,
        M_QUOTE_BS = 3'd5,
        M_STOPPED  = 3'd6
    } mode_t;

    typedef struct packed {
        logic multiline;
        logic extended;
        logic unsupported;
    } flags_t;

    typedef struct packed {
        byte_t                 prefix_char;
        logic                  char_valid;
        logic                  done_res;
        logic [LEN_WIDTH-1:0]  prefix_length;
        logic                  exact;
    } result_t;

    typedef struct packed {
        logic [RES_IDX_WIDTH-1:0]  count;
        result_t [MAX_RESULTS-1:0] res;
    } result_list_t;

    function automatic logic is_meta(byte_t c);
        return c == CH_CARET || c == CH_DOLLAR || c == CH_DOT || c == CH_LBRACKET ||
               c == CH_LPAREN || c == CH_RPAREN || c == CH_PLUS || c == CH_LBRACE;
    endfunction

    function automatic logic is_alnum(byte_t c);
        return (c >= 8'h41 && c <= 8'h5A) || (c >= 8'h61 && c <= 8'h7A) ||
               (c >= 8'h30 && c <= 8'h39);
    endfunction

    function automatic logic is_space(byte_t c);
        return (c >= 8'h09 && c <= 8'h0D) || c == CH_SPACE;
    endfunction

endpackage
`default_nettype wire

FILE: src/rlpe_step.sv
`default_nettype none
module rlpe_step #(
    parameter int COUNT_WIDTH = rlpe_pkg::COUNT_WIDTH_DEF
) (
    input  var rlpe_pkg::mode_t        mode_i,
    input  var logic [COUNT_WIDTH-1:0] count_i,
    input  var rlpe_pkg::flags_t       flags_i,
    input  var rlpe_pkg::byte_t        chr_i,
    input  var logic                   present_i,
    input  var logic                   eop_i,
    output rlpe_pkg::mode_t            mode_o,
    output logic [COUNT_WIDTH-1:0]     count_o,
    output rlpe_pkg::result_list_t     list_o
);
    import rlpe_pkg::*;

    localparam logic [COUNT_WIDTH-1:0] CNT_MAX = '1;

    mode_t                    m;
    logic [COUNT_WIDTH-1:0]   cnt;
    logic [RES_IDX_WIDTH-1:0] n;
    logic [31:0]              len_wide;
    logic                     ex;

    function automatic logic [COUNT_WIDTH-1:0] inc_sat(logic [COUNT_WIDTH-1:0] v);
        return (v == CNT_MAX) ? v : v + 1'b1;
    endfunction

    function automatic result_t char_res(byte_t c);
        result_t r;
        r = '0;
        r.prefix_char = c;
        r.char_valid  = 1'b1;
        return r;
    endfunction

    always_comb begin
        m        = mode_i;
        cnt      = count_i;
        n        = '0;
        len_wide = '0;
        ex       = 1'b0;
        list_o   = '0;

        if (present_i) begin
            case (mode_i)
                M_START: begin
                    if (chr_i == CH_CARET) begin
                        if (flags_i.unsupported || flags_i.multiline) begin
                            m   = M_STOPPED;
                            cnt = '0;
                        end else begin
                            m = M_SCAN;
                        end
                    end else if (chr_i == CH_BACKSLASH) begin
                        m = M_START_BS;
                    end else begin
                        m   = M_STOPPED;
                        cnt = '0;
                    end
                end
                M_START_BS: begin
                    if (chr_i == CH_A && !flags_i.unsupported) begin
                        m = M_SCAN;
                    end else begin
                        m   = M_STOPPED;
                        cnt = '0;
                    end
                end
                M_SCAN: begin
                    if (chr_i == CH_STAR || chr_i == CH_QMARK) begin
                        m   = M_STOPPED;
                        cnt = (count_i != '0) ? count_i - 1'b1 : '0;
                    end else if (chr_i == CH_BAR) begin
                        m   = M_STOPPED;
                        cnt = '0;
                    end else if (chr_i == CH_BACKSLASH) begin
                        m = M_SCAN_BS;
                    end else if (is_meta(chr_i) || (flags_i.extended && chr_i == CH_HASH)) begin
                        m = M_STOPPED;
                    end else if (!(flags_i.extended && is_space(chr_i))) begin
                        list_o.res[n] = char_res(chr_i);
                        n   = n + 1'b1;
                        cnt = inc_sat(cnt);
                    end
                end
                M_SCAN_BS: begin
                    if (chr_i == CH_Q) begin
                        m = M_QUOTE;
                    end else if (is_alnum(chr_i) || chr_i == 8'h00) begin
                        m = M_STOPPED;
                    end else begin
                        list_o.res[n] = char_res(chr_i);
                        n   = n + 1'b1;
                        cnt = inc_sat(cnt);
                        m   = M_SCAN;
                    end
                end
                M_QUOTE: begin
                    if (chr_i == CH_BACKSLASH) begin
                        m = M_QUOTE_BS;
                    end else begin
                        list_o.res[n] = char_res(chr_i);
                        n   = n + 1'b1;
                        cnt = inc_sat(cnt);
                    end
                end
                M_QUOTE_BS: begin
                    if (chr_i == CH_E) begin
                        m = M_SCAN;
                    end else begin
                        list_o.res[n] = char_res(CH_BACKSLASH);
                        n   = n + 1'b1;
                        cnt = inc_sat(cnt);
                        if (chr_i != CH_BACKSLASH) begin
                            list_o.res[n] = char_res(chr_i);
                            n   = n + 1'b1;
                            cnt = inc_sat(cnt);
                            m   = M_QUOTE;
                        end
                    end
                end
                default: ;
            endcase
        end

        if (eop_i) begin
            case (m)
                M_SCAN, M_QUOTE: begin
                    len_wide = 32'(cnt);
                    ex       = (cnt != '0);
                end
                M_QUOTE_BS: begin
                    list_o.res[n] = char_res(CH_BACKSLASH);
                    n        = n + 1'b1;
                    cnt      = inc_sat(cnt);
                    len_wide = 32'(cnt);
                    ex       = 1'b1;
                end
                M_START, M_START_BS: begin
                    len_wide = '0;
                end
                default: begin
                    len_wide = 32'(cnt);
                end
            endcase
            list_o.res[n].done_res      = 1'b1;
            list_o.res[n].prefix_length = (len_wide > 32'h0000_FFFF) ?
                                          16'hFFFF : len_wide[LEN_WIDTH-1:0];
            list_o.res[n].exact         = ex;
            n   = n + 1'b1;
            m   = M_START;
            cnt = '0;
        end

        list_o.count = n;
        mode_o       = m;
        count_o      = cnt;
    end

endmodule
`default_nettype wire

FILE: src/regex_literal_prefix_extractor.sv
`default_nettype none
// Streams a regular-expression pattern in one byte per transfer (s_tuser
// marks a byte as present, s_tlast ends the pattern) and streams out the
// literal prefix that every match must begin with, one byte per transfer,
// followed by a final transfer with m_tlast set that carries the prefix
// length and the exact flag. A pattern byte is accepted every cycle unless
// a result waits on m_tready; the parser state updates in one step between
// the input and output registers. An item with two or three results (the
// byte after a backslash inside a quoted run, or a literal byte that also
// ends the pattern) holds the input register while the output register
// takes one result per cycle as m_tready allows. The user writes the flag
// registers through the cfg port between patterns; the block does not check.
module regex_literal_prefix_extractor #(
    parameter int COUNT_WIDTH = rlpe_pkg::COUNT_WIDTH_DEF
) (
    input  var logic                                 aclk,
    input  var logic                                 aresetn,
    input  var logic                                 s_tvalid,
    output logic                                     s_tready,
    input  var logic [7:0]                           s_tdata,  // [7:0] pattern_char
    input  var logic                                 s_tuser,  // [0] char_present
    input  var logic                                 s_tlast,
    output logic                                     m_tvalid,
    input  var logic                                 m_tready,
    output logic [31:0]                              m_tdata,  // [7:0] prefix_char,
                                                                // [23:8] prefix_length,
                                                                // [24] exact
    output logic                                     m_tuser,  // [0] char_valid
    output logic                                     m_tlast,
    input  var logic                                 cfg_valid,
    output logic                                     cfg_ready,
    input  var logic [rlpe_pkg::CFG_INDEX_WIDTH-1:0] cfg_index,
    input  var logic                                 cfg_data
);
    import rlpe_pkg::*;

    flags_t                   flags_reg;
    mode_t                    mode_reg, mode_next;
    logic [COUNT_WIDTH-1:0]   count_reg, count_next;

    logic                     in_valid_reg;
    byte_t                    in_char_reg;
    logic                     in_present_reg;
    logic                     in_eop_reg;

    logic [RES_IDX_WIDTH-1:0] phase_reg;

    logic                     out_valid_reg;
    result_t                  out_reg;

    result_list_t             list;
    logic                     out_free;
    logic                     consume;
    logic                     emit;

    assign cfg_ready = 1'b1;

    rlpe_step #(
        .COUNT_WIDTH(COUNT_WIDTH)
    ) u_step (
        .mode_i    (mode_reg),
        .count_i   (count_reg),
        .flags_i   (flags_reg),
        .chr_i     (in_char_reg),
        .present_i (in_present_reg),
        .eop_i     (in_eop_reg),
        .mode_o    (mode_next),
        .count_o   (count_next),
        .list_o    (list)
    );

    assign out_free = !out_valid_reg || m_tready;
    assign emit     = in_valid_reg && out_free && (list.count != '0);
    assign consume  = in_valid_reg &&
                      ((list.count == '0) ||
                       (out_free && (phase_reg == list.count - 1'b1)));
    assign s_tready = !in_valid_reg || consume;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            flags_reg <= '0;
        end else if (cfg_valid && cfg_ready) begin
            unique case (cfg_index)
                REG_FLAG_MULTILINE:   flags_reg.multiline   <= cfg_data;
                REG_FLAG_EXTENDED:    flags_reg.extended    <= cfg_data;
                REG_FLAG_UNSUPPORTED: flags_reg.unsupported <= cfg_data;
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_tready) begin
            in_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tready && s_tvalid) begin
            in_char_reg    <= s_tdata;
            in_present_reg <= s_tuser;
            in_eop_reg     <= s_tlast;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg  <= M_START;
            count_reg <= '0;
            phase_reg <= '0;
        end else begin
            if (consume) begin
                mode_reg  <= mode_next;
                count_reg <= count_next;
                phase_reg <= '0;
            end else if (emit) begin
                phase_reg <= phase_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (out_free) begin
            out_valid_reg <= emit;
        end
    end

    always_ff @(posedge aclk) begin
        if (emit) begin
            out_reg <= list.res[phase_reg];
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {7'd0, out_reg.exact, out_reg.prefix_length, out_reg.prefix_char};
    assign m_tuser  = out_reg.char_valid;
    assign m_tlast  = out_reg.done_res;

    a_final_no_char: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tlast |-> !m_tuser)
        else $error("final result carries a prefix character");

    a_mid_is_char: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tlast |-> m_tuser && m_tdata[24:8] == 17'd0)
        else $error("non-final result without a prefix character");

    a_phase_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        phase_reg != 2'd0 |-> in_valid_reg && phase_reg < list.count)
        else $error("result phase outside the current item");

    a_rearm: assert property (@(posedge aclk) disable iff (!aresetn)
        consume && in_eop_reg |=> mode_reg == M_START && count_reg == '0)
        else $error("parser not rearmed after end of pattern");

endmodule
`default_nettype wire

FILE: tb/regex_literal_prefix_extractor_tb.sv
`timescale 1ns / 1ps
module regex_literal_prefix_extractor_tb;
    import rlpe_pkg::*;

    localparam int HOLD_CYCLES    = 300;
    localparam int SETTLE_CYCLES  = 10;
    localparam int WATCHDOG_LIMIT = 3000;
    localparam int RANDOM_ITEMS   = 90;

    logic                       aclk      = 1'b0;
    logic                       aresetn   = 1'b0;
    logic                       s_tvalid  = 1'b0;
    logic                       s_tready;
    logic [7:0]                 s_tdata   = '0;
    logic                       s_tuser   = 1'b0;
    logic                       s_tlast   = 1'b0;
    logic                       m_tvalid;
    logic                       m_tready  = 1'b0;
    logic [31:0]                m_tdata;
    logic                       m_tuser;
    logic                       m_tlast;
    logic                       cfg_valid = 1'b0;
    logic                       cfg_ready;
    logic [CFG_INDEX_WIDTH-1:0] cfg_index = '0;
    logic                       cfg_data  = 1'b0;

    // predictor state
    mode_t                scan_mode  = M_START;
    logic [LEN_WIDTH-1:0] scan_count = '0;
    flags_t               cur_flags  = '0;
    result_t              prefix_results[$];

    int errors        = 0;
    int parsed_items  = 0;
    int idle_cycles   = 0;
    int hold_requests = 0;
    int holds_served  = 0;
    int hold_left     = 0;
    bit calm          = 1'b0;

    regex_literal_prefix_extractor u_top (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .s_tlast   (s_tlast),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .m_tlast   (m_tlast),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    function automatic void push_result(byte_t ch, logic valid, logic done,
                                        logic [LEN_WIDTH-1:0] len, logic ex);
        result_t r;
        r.prefix_char   = ch;
        r.char_valid    = valid;
        r.done_res      = done;
        r.prefix_length = len;
        r.exact         = ex;
        prefix_results = {prefix_results, r};
    endfunction

    function automatic void emit_literal(byte_t ch);
        push_result(ch, 1'b1, 1'b0, '0, 1'b0);
        if (scan_count != '1)
            scan_count = scan_count + 1'b1;
    endfunction

    function automatic void halt_scan(logic [LEN_WIDTH-1:0] len);
        scan_count = len;
        scan_mode  = M_STOPPED;
    endfunction

    function automatic void take_anchor(logic after_a);
        if (cur_flags.unsupported || (cur_flags.multiline && !after_a))
            halt_scan('0);
        else
            scan_mode = M_SCAN;
    endfunction

    function automatic void predict_prefix(byte_t ch, logic present, logic last);
        logic [LEN_WIDTH-1:0] len;
        logic                 ex;
        logic                 meta;
        logic                 blank;
        logic                 alnum;
        len   = '0;
        ex    = 1'b0;
        meta  = ch == CH_CARET || ch == CH_DOLLAR || ch == CH_DOT || ch == CH_LBRACKET ||
                ch == CH_LPAREN || ch == CH_RPAREN || ch == CH_PLUS || ch == CH_LBRACE;
        blank = (ch >= 8'h09 && ch <= 8'h0D) || ch == CH_SPACE;
        alnum = (ch >= "A" && ch <= "Z") || (ch >= "a" && ch <= "z") ||
                (ch >= "0" && ch <= "9");
        if (present) begin
            case (scan_mode)
                M_START: begin
                    if (ch == CH_CARET)
                        take_anchor(1'b0);
                    else if (ch == CH_BACKSLASH)
                        scan_mode = M_START_BS;
                    else
                        halt_scan('0);
                end
                M_START_BS: begin
                    if (ch == CH_A)
                        take_anchor(1'b1);
                    else
                        halt_scan('0);
                end
                M_SCAN: begin
                    if (ch == CH_STAR || ch == CH_QMARK)
                        halt_scan((scan_count == '0) ? '0 : scan_count - 1'b1);
                    else if (ch == CH_BAR)
                        halt_scan('0);
                    else if (ch == CH_BACKSLASH)
                        scan_mode = M_SCAN_BS;
                    else if (meta || (cur_flags.extended && ch == CH_HASH))
                        halt_scan(scan_count);
                    else if (!(cur_flags.extended && blank))
                        emit_literal(ch);
                end
                M_SCAN_BS: begin
                    if (ch == CH_Q) begin
                        scan_mode = M_QUOTE;
                    end else if (alnum || ch == 8'h00) begin
                        halt_scan(scan_count);
                    end else begin
                        emit_literal(ch);
                        scan_mode = M_SCAN;
                    end
                end
                M_QUOTE: begin
                    if (ch == CH_BACKSLASH)
                        scan_mode = M_QUOTE_BS;
                    else
                        emit_literal(ch);
                end
                M_QUOTE_BS: begin
                    if (ch == CH_E) begin
                        scan_mode = M_SCAN;
                    end else if (ch == CH_BACKSLASH) begin
                        emit_literal(CH_BACKSLASH);
                    end else begin
                        emit_literal(CH_BACKSLASH);
                        emit_literal(ch);
                        scan_mode = M_QUOTE;
                    end
                end
                default: ;
            endcase
        end
        if (last) begin
            case (scan_mode)
                M_SCAN, M_QUOTE: begin
                    len = scan_count;
                    ex  = scan_count != '0;
                end
                M_QUOTE_BS: begin
                    emit_literal(CH_BACKSLASH);
                    len = scan_count;
                    ex  = 1'b1;
                end
                M_START, M_START_BS: len = '0;
                default: len = scan_count;
            endcase
            push_result(8'h00, 1'b0, 1'b1, len, ex);
            scan_mode  = M_START;
            scan_count = '0;
        end
    endfunction

    always @(posedge aclk) begin
        if (hold_left > 0) begin
            hold_left <= hold_left - 1;
            m_tready  <= 1'b0;
        end else if (holds_served != hold_requests) begin
            holds_served <= holds_served + 1;
            hold_left    <= HOLD_CYCLES;
            m_tready     <= 1'b0;
        end else begin
            m_tready <= calm || ($urandom_range(99) >= 6);
        end
    end

    always @(posedge aclk) begin
        result_t want;
        if (aresetn && m_tvalid && m_tready) begin
            if (prefix_results.size() == 0) begin
                $error("unexpected result transfer: m_tdata %0h m_tuser %0b m_tlast %0b",
                       m_tdata, m_tuser, m_tlast);
                errors++;
            end else begin
                want = prefix_results.pop_front();
                if (m_tdata[7:0] !== want.prefix_char) begin
                    $error("prefix_char: expected %0h, actual %0h",
                           want.prefix_char, m_tdata[7:0]);
                    errors++;
                end
                if (m_tuser !== want.char_valid) begin
                    $error("char_valid: expected %0b, actual %0b", want.char_valid, m_tuser);
                    errors++;
                end
                if (m_tlast !== want.done_res) begin
                    $error("done_res: expected %0b, actual %0b", want.done_res, m_tlast);
                    errors++;
                end
                if (m_tdata[23:8] !== want.prefix_length) begin
                    $error("prefix_length: expected %0d, actual %0d",
                           want.prefix_length, m_tdata[23:8]);
                    errors++;
                end
                if (m_tdata[24] !== want.exact) begin
                    $error("exact: expected %0b, actual %0b", want.exact, m_tdata[24]);
                    errors++;
                end
            end
        end
    end

    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("DONE: errors detected");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    task automatic send_item(input byte_t ch, input logic present, input logic last);
        while (!calm && $urandom_range(99) < 6) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= ch;
        s_tuser  <= present;
        s_tlast  <= last;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        predict_prefix(ch, present, last);
        if (present || last)
            parsed_items++;
    endtask

    task automatic send_text(input string txt, input logic end_on_last);
        for (int i = 0; i < txt.len(); i++)
            send_item(txt[i], 1'b1, end_on_last && (i == txt.len() - 1));
    endtask

    task automatic wait_results();
        s_tvalid <= 1'b0;
        while (prefix_results.size() != 0) @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    task automatic write_reg(input reg_index_t idx, input logic val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge aclk);
        while (!cfg_ready) @(posedge aclk);
        case (idx)
            REG_FLAG_MULTILINE: cur_flags.multiline = val;
            REG_FLAG_EXTENDED:  cur_flags.extended  = val;
            default:            cur_flags.unsupported = val;
        endcase
    endtask

    task automatic set_flags(input logic ml, input logic ext, input logic uns);
        wait_results();
        write_reg(REG_FLAG_MULTILINE, ml);
        write_reg(REG_FLAG_EXTENDED, ext);
        write_reg(REG_FLAG_UNSUPPORTED, uns);
        cfg_valid <= 1'b0;
    endtask

    task automatic test_anchors_and_metachars();
        set_flags(1'b0, 1'b0, 1'b0);
        send_text("^*", 1'b1);
        send_text("^ab|", 1'b1);
        send_text("y", 1'b1);
        send_text("\\B", 1'b1);
        send_text("^a\\", 1'b1);
    endtask

    task automatic test_escapes_and_quoting();
        send_text("\\Aq\\.", 1'b0);
        send_item(8'hFF, 1'b1, 1'b1);
        send_text("^\\Q\\x\\", 1'b1);
        send_item(CH_CARET, 1'b1, 1'b0);
        send_item(8'h00, 1'b1, 1'b0);
        send_item(8'hA5, 1'b0, 1'b0);
        send_item(CH_BACKSLASH, 1'b1, 1'b0);
        send_item(8'h00, 1'b1, 1'b0);
        send_item(8'h5A, 1'b0, 1'b1);
    endtask

    task automatic test_flag_registers();
        set_flags(1'b0, 1'b1, 1'b0);
        send_text("^a\tb #c", 1'b1);
        set_flags(1'b1, 1'b0, 1'b0);
        send_text("^a", 1'b1);
        send_text("\\Ab", 1'b1);
        set_flags(1'b1, 1'b1, 1'b1);
        send_text("\\Ab", 1'b1);
        set_flags(1'b0, 1'b0, 1'b0);
    endtask

    task automatic test_receiver_holdoff();
        hold_requests <= hold_requests + 1;
        send_item(CH_CARET, 1'b1, 1'b0);
        for (int i = 0; i < 24; i++)
            send_item(byte_t'("a" + i), 1'b1, i == 23);
        wait_results();
    endtask

    task automatic test_back_to_back();
        calm = 1'b1;
        send_item(CH_CARET, 1'b1, 1'b0);
        for (int i = 0; i < 60; i++)
            send_item(byte_t'("a" + (i % 26)), 1'b1, 1'b0);
        send_item(CH_STAR, 1'b1, 1'b1);
        wait_results();
        calm = 1'b0;
    endtask

    task automatic send_random_pattern();
        byte_t pat[$];
        byte_t ch;
        int    pick;
        logic  tail_end;
        pick = $urandom_range(99);
        if (pick < 8) begin
            repeat ($urandom_range(6, 1)) pat = {pat, byte_t'($urandom_range(255))};
        end else begin
            if (pick < 50) begin
                pat = {pat, CH_CARET};
            end else if (pick < 88) begin
                pat = {pat, CH_BACKSLASH, CH_A};
            end else if (pick < 94) begin
                pat = {pat, CH_BACKSLASH, byte_t'($urandom_range(255))};
            end else begin
                pat = {pat, byte_t'($urandom_range(255))};
            end
            repeat ($urandom_range(10)) begin
                pick = $urandom_range(99);
                if (pick < 45) begin
                    pat = {pat, byte_t'($urandom_range(8'h7A, 8'h61))};
                end else if (pick < 55) begin
                    pat = {pat, byte_t'($urandom_range(8'h7E, 8'h20))};
                end else if (pick < 63) begin
                    pat = {pat, CH_BACKSLASH, byte_t'($urandom_range(8'h7E, 8'h20))};
                end else if (pick < 68) begin
                    pat = {pat, CH_BACKSLASH, CH_Q};
                end else if (pick < 73) begin
                    pat = {pat, CH_BACKSLASH, CH_E};
                end else if (pick < 76) begin
                    pat = {pat, CH_BACKSLASH};
                end else if (pick < 90) begin
                    case ($urandom_range(13))
                        0:       ch = CH_STAR;
                        1:       ch = CH_QMARK;
                        2:       ch = CH_BAR;
                        3:       ch = CH_CARET;
                        4:       ch = CH_DOLLAR;
                        5:       ch = CH_DOT;
                        6:       ch = CH_LBRACKET;
                        7:       ch = CH_LPAREN;
                        8:       ch = CH_RPAREN;
                        9:       ch = CH_PLUS;
                        10:      ch = CH_LBRACE;
                        11:      ch = CH_HASH;
                        12:      ch = CH_SPACE;
                        default: ch = byte_t'($urandom_range(8'h0D, 8'h09));
                    endcase
                    pat = {pat, ch};
                end else begin
                    pat = {pat, byte_t'($urandom_range(255))};
                end
            end
        end
        tail_end = pat.size() > 0 && $urandom_range(99) < 70;
        foreach (pat[i]) begin
            if ($urandom_range(99) < 4)
                send_item(byte_t'($urandom_range(255)), 1'b0, 1'b0);
            send_item(pat[i], 1'b1, tail_end && (i == pat.size() - 1));
        end
        if (!tail_end)
            send_item(byte_t'($urandom_range(255)), 1'b0, 1'b1);
    endtask

    task automatic test_random_patterns();
        int first;
        first = parsed_items;
        while (parsed_items - first < RANDOM_ITEMS) begin
            if ($urandom_range(99) < 7)
                set_flags($urandom_range(99) < 30, 1'($urandom_range(1)),
                          $urandom_range(99) < 10);
            send_random_pattern();
        end
        set_flags(1'b1, 1'b1, 1'b1);
        send_text("\\Aa", 1'b1);
        set_flags(1'b0, 1'b0, 1'b0);
    endtask

    initial begin
        repeat (6) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        test_anchors_and_metachars();
        test_escapes_and_quoting();
        test_flag_registers();
        test_receiver_holdoff();
        test_back_to_back();
        test_random_patterns();
        wait_results();
        if (errors == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule
